// ===== rtl/core/lpht_pkg.sv =====
package lpht_pkg;

  // table geometry
  localparam int unsigned SLOT_COUNT = 1024;
  localparam int unsigned SLOT_BITS  = $clog2(SLOT_COUNT);
  localparam int unsigned COUNT_BITS = SLOT_BITS + 1;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 32;

  // fill limit register
  localparam int unsigned FILL_BITS = 10;
  localparam logic [FILL_BITS-1:0] FILL_LIMIT_RESET = 10'd768;

  // request operations
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_HIT       = 3'd3,
    ST_MISS      = 3'd4,
    ST_ZERO_HASH = 3'd5
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE
  } state_e;

  // one slot word in the table memory
  typedef struct packed {
    logic                  occ;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  // memory access bundle from controller to slot memory
  typedef struct packed {
    logic                 we;
    logic [SLOT_BITS-1:0] waddr;
    slot_t                wdata;
    logic [SLOT_BITS-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/core/lpht_slot_ram.sv =====
module lpht_slot_ram #(
  parameter int unsigned ADDR_BITS = 10,
  parameter int unsigned DATA_BITS = 65
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [DATA_BITS-1:0] wdata_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [DATA_BITS-1:0] rdata_o
);

  logic [DATA_BITS-1:0] mem_q [2**ADDR_BITS];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/lpht_ctrl.sv =====
module lpht_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            operation_i,
  input  logic [31:0]                     key_i,
  input  logic [31:0]                     value_i,
  input  logic [31:0]                     hash_i,
  input  logic [lpht_pkg::FILL_BITS-1:0]  fill_limit_i,
  output logic                            done_o,
  output logic [2:0]                      status_o,
  output logic [31:0]                     found_value_o,
  output lpht_pkg::mem_req_t              mem_req_o,
  input  logic [lpht_pkg::SLOT_W-1:0]     mem_rdata_i
);
  import lpht_pkg::*;

  state_e                 state_q, state_d;
  logic [SLOT_BITS-1:0]   addr_q, addr_d;
  logic [SLOT_BITS-1:0]   cnt_q, cnt_d;
  logic [COUNT_BITS-1:0]  occ_cnt_q, occ_cnt_d;
  op_e                    op_q, op_d;
  logic [KEY_BITS-1:0]    key_q, key_d;
  logic [VALUE_BITS-1:0]  value_q, value_d;
  logic                   done_q, done_d;
  status_e                status_q, status_d;
  logic [31:0]            found_q, found_d;

  slot_t                  rd_slot;
  logic                   slot_empty;
  logic                   slot_hit;
  logic                   probe_last;
  logic                   clear_last;
  logic                   at_limit;
  logic [SLOT_BITS-1:0]   home_slot;
  slot_t                  wr_slot;

  // decode of the slot word read back this cycle
  assign rd_slot    = slot_t'(mem_rdata_i);
  assign slot_empty = !rd_slot.occ;
  assign slot_hit   = rd_slot.occ && (rd_slot.key == key_q);
  assign probe_last = (cnt_q == SLOT_BITS'(SLOT_COUNT - 1));
  assign clear_last = (addr_q == SLOT_BITS'(SLOT_COUNT - 1));
  assign at_limit   = (occ_cnt_q >= COUNT_BITS'(fill_limit_i));
  assign home_slot  = hash_i[SLOT_BITS-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start && (hash_i != '0)) state_d = S_PROBE;
      end
      S_PROBE: begin
        if (slot_empty || slot_hit || probe_last) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    addr_d    = addr_q;
    cnt_d     = cnt_q;
    occ_cnt_d = occ_cnt_q;
    op_d      = op_q;
    key_d     = key_q;
    value_d   = value_q;
    done_d    = 1'b0;
    status_d  = status_q;
    found_d   = found_q;

    wr_slot       = '0;
    wr_slot.key   = key_q;
    wr_slot.value = value_q;

    mem_req_o       = '0;
    mem_req_o.waddr = addr_q;
    mem_req_o.raddr = addr_q + 1'b1;

    unique case (state_q)
      S_CLEAR: begin
        // sweep every slot to empty
        mem_req_o.we    = 1'b1;
        mem_req_o.wdata = '0;
        addr_d          = addr_q + 1'b1;
      end
      S_IDLE: begin
        mem_req_o.raddr = home_slot;
        if (start) begin
          op_d    = op_e'(operation_i);
          key_d   = key_i[KEY_BITS-1:0];
          value_d = value_i[VALUE_BITS-1:0];
          addr_d  = home_slot;
          cnt_d   = '0;
          if (hash_i == '0) begin
            done_d   = 1'b1;
            status_d = ST_ZERO_HASH;
            found_d  = '0;
          end
        end
      end
      S_PROBE: begin
        if (slot_empty) begin
          // end of the probe run, key absent
          done_d  = 1'b1;
          found_d = '0;
          if (op_q == OP_LOOKUP) begin
            status_d = ST_MISS;
          end else if (at_limit) begin
            status_d = ST_FULL;
          end else begin
            wr_slot.occ     = 1'b1;
            mem_req_o.we    = 1'b1;
            mem_req_o.wdata = wr_slot;
            occ_cnt_d       = occ_cnt_q + 1'b1;
            status_d        = ST_INSERTED;
          end
        end else if (slot_hit) begin
          done_d = 1'b1;
          if (op_q == OP_LOOKUP) begin
            status_d = ST_HIT;
            found_d  = 32'(rd_slot.value);
          end else begin
            status_d = ST_PRESENT;
            found_d  = '0;
          end
        end else if (probe_last) begin
          // wrapped all the way round without a match or a hole
          done_d   = 1'b1;
          found_d  = '0;
          status_d = (op_q == OP_LOOKUP) ? ST_MISS : ST_FULL;
        end else begin
          addr_d = addr_q + 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      addr_q    <= '0;
      cnt_q     <= '0;
      occ_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      addr_q    <= addr_d;
      cnt_q     <= cnt_d;
      occ_cnt_q <= occ_cnt_d;
      done_q    <= done_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    value_q  <= value_d;
    status_q <= status_d;
    found_q  <= found_d;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_value_o = found_q;

endmodule

// ===== rtl/core/linear_probe_hash_table.sv =====
// Fixed-size open-addressing key/value table with linear probing. A request
// is taken when start is high and busy is low; its result appears on status_o
// and found_value_o for exactly one cycle with done_o high, and must be taken
// then, since the receiver cannot hold it off. The probe reads one slot per
// cycle from a single-port-read table memory, and a request visits from 1 up
// to 1024 slots before its result is shown; a zero-hash request is answered
// in the cycle after it is taken, without a probe. busy falls in the cycle
// the result is shown, so the next request can be taken then. After reset the
// block sweeps all 1024 slots to empty, holding busy high until it is done;
// fill_limit writes are taken at any time the block is idle.
module linear_probe_hash_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  input  logic [31:0] hash_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] found_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [9:0]  cfg_data_i
);
  import lpht_pkg::*;

  logic [FILL_BITS-1:0] fill_limit_q;
  mem_req_t             mem_req;
  logic [SLOT_W-1:0]    mem_rdata;

  // fill limit register, written only between probe runs
  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_limit_q <= FILL_LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fill_limit_q <= cfg_data_i[FILL_BITS-1:0];
    end
  end

  // probe controller
  lpht_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .hash_i        (hash_i),
    .fill_limit_i  (fill_limit_q),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_value_o (found_value_o),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata)
  );

  // slot table memory
  lpht_slot_ram #(
    .ADDR_BITS (SLOT_BITS),
    .DATA_BITS (SLOT_W)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== rtl/core/lpht_checker.sv =====
module lpht_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [31:0] hash_i,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic [31:0] found_value_o
);
  import lpht_pkg::*;

  // a zero-hash request is answered in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (hash_i == '0) |=> done_o && (status_o == ST_ZERO_HASH))
    else $error("zero hash request not rejected at once");

  // a real request starts a probe run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (hash_i != '0) |=> busy && !done_o)
    else $error("probe did not start");

  // a result is only shown while the block is ready for the next request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // only a lookup hit carries a value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_HIT) |-> (found_value_o == '0))
    else $error("nonzero value on a non-hit result");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);
